@@ design/assert_macros.svh @@
// Assertion macros used by the checker file msb_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/msb_pkg.sv @@
package msb_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;

	// broadcast to every cell in the row
	typedef struct packed {
		logic                     ins;    // insert value this cycle
		logic                     shl;    // shift whole row toward cell 0
		logic signed [DATA_W-1:0] value;  // item being inserted
	} cell_ctrl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic                     vld;
		logic signed [DATA_W-1:0] val;
		logic                     take;   // empty, or holds a value above the new item
	} cell_link_t;

endpackage

@@ design/merge_sort_block.sv @@
// channel   dir  fields (lsb first)                 accepted when
// s_axis    in   tdata: value[31:0]; tlast: last    s_axis_tvalid & s_axis_tready
// m_axis    out  tdata: sorted_value[31:0];          m_axis_tvalid & m_axis_tready
//                tlast: last_out; tuser: dropped
//
// For each item taken while the row is not full, the DEPTH cells do a parallel
// compare against the new item and shift the larger entries one place right.
// After the last item the row holds the sorted list; emitting shifts it toward
// cell 0 at one item per cycle while the output is not stalled, and the next
// list's first item can be taken in the cycle after the last item leaves.
// Reset empties the row. Input is not taken while a list is being emitted, and
// a stalled output holds cell 0 and the whole row unchanged.
module merge_sort_block (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // value[31:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // sorted_value[31:0]
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // dropped
);
	import msb_pkg::*;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic       overflow_q;
	logic       in_acc;
	logic       out_acc;
	logic       full;
	cell_ctrl_t ctrl;
	cell_link_t link [DEPTH];
	cell_link_t lnk_none;

	assign lnk_none = '{vld: 1'b0, val: '0, take: 1'b0};

	assign full    = link[DEPTH-1].vld;
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	assign ctrl.ins   = in_acc && !full;
	assign ctrl.shl   = out_acc;
	assign ctrl.value = s_axis_tdata;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign m_axis_tvalid = (state_q == ST_EMIT);
	assign m_axis_tdata  = link[0].val;
	assign m_axis_tlast  = !link[1].vld;
	assign m_axis_tuser  = overflow_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_link_t lft;
		cell_link_t rgt;
		if (i == 0) begin : g_first
			assign lft = lnk_none;
		end else begin : g_mid
			assign lft = link[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign rgt = lnk_none;
		end else begin : g_inner
			assign rgt = link[i+1];
		end
		msb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.lft    (lft),
			.rgt    (rgt),
			.link   (link[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			overflow_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							overflow_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					// final item leaves when cell 1 is already empty
					if (out_acc && !link[1].vld) begin
						state_q    <= ST_LOAD;
						overflow_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

@@ design/msb_cell.sv @@
module msb_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  msb_pkg::cell_ctrl_t ctrl,
	input  msb_pkg::cell_link_t lft,
	input  msb_pkg::cell_link_t rgt,
	output msb_pkg::cell_link_t link
);
	import msb_pkg::*;

	logic                     vld_q;
	logic signed [DATA_W-1:0] val_q;
	logic                     take;

	// strict compare keeps equal values in arrival order
	assign take = !vld_q || (val_q > ctrl.value);

	assign link.vld  = vld_q;
	assign link.val  = val_q;
	assign link.take = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.ins) begin
			if (lft.take) begin
				vld_q <= lft.vld;
			end else if (take) begin
				vld_q <= 1'b1;
			end
		end else if (ctrl.shl) begin
			vld_q <= rgt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (lft.take) begin
				val_q <= lft.val;
			end else if (take) begin
				val_q <= ctrl.value;
			end
		end else if (ctrl.shl) begin
			val_q <= rgt.val;
		end
	end

endmodule

@@ design/msb_chk.sv @@
`include "assert_macros.svh"

module msb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	`CHK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output item changed")
	`CHK_SAME(a_one_side, s_axis_tready, !m_axis_tvalid, "input taken while emitting")
	`CHK_NEXT(a_list_done, s_axis_tvalid && s_axis_tready && s_axis_tlast, m_axis_tvalid, "no output after last input item")
	`CHK_NEXT(a_ascending, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && ($signed(m_axis_tdata) >= $signed($past(m_axis_tdata))), "output not ascending")

endmodule

bind merge_sort_block msb_chk u_msb_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
